@@ src/assert_macros.svh @@
// Concurrent assertion helpers for the plane projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZAP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/zap_pkg.sv @@
package zap_pkg;

   localparam int TABLE_LEN = 24;
   localparam int ROTATION_STAGES_DEF = 16;

   localparam int ZEN_W = 16;
   localparam int AZ_W = 17;
   localparam int REM_W = 15;
   localparam int ANG_MUL_W = 25;
   localparam int XY_W = 34;
   localparam int Z_W = 32;
   localparam int MAG_W = 32;
   localparam int PROD_W = ZEN_W + MAG_W;
   localparam int T_W = 23;
   localparam int RECIP_W = 27;
   localparam int Q_W = 18;

   localparam logic [AZ_W-1:0] QUARTER_Q8 = 17'd23040;
   localparam logic [AZ_W-1:0] HALF_Q8 = 17'd46080;
   localparam logic [AZ_W-1:0] THREE_Q_Q8 = 17'd69120;
   localparam logic [AZ_W-1:0] FULL_Q8 = 17'd92160;

   localparam logic [ANG_MUL_W-1:0] DEG_Q8_TO_RAD = 25'd18740330;
   localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

   // The output divisor is 45 * 2**25; rounding adds half of it.
   localparam logic [PROD_W-1:0] OUT_HALF = 48'd754974720;
   localparam int OUT_SHIFT = 25;
   localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443717;
   localparam int RECIP_SHIFT = 32;
   localparam logic [T_W-1:0] DIV_FACTOR = 23'd45;

   localparam logic [Q_W-1:0] POS_LIMIT = 18'd32767;
   localparam logic [Q_W-1:0] NEG_LIMIT = 18'd32768;

   localparam logic signed [Z_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
      32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
      32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
      32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
      32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
      32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
      32'sd1024,      32'sd512,       32'sd256,       32'sd128
   };

   typedef enum logic [1:0] {
      QUAD_FIRST,
      QUAD_SECOND,
      QUAD_THIRD,
      QUAD_FOURTH
   } zap_quad_type;

   typedef struct packed {
      logic [ZEN_W-1:0] zenith_deg;
      logic [AZ_W-1:0]  azimuth_deg;
   } zap_req_type;

   typedef struct packed {
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
   } zap_rsp_type;

   typedef struct packed {
      logic [ZEN_W-1:0]       zen;
      zap_quad_type           quad;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } zap_rot_type;

endpackage

@@ src/zap_front.sv @@
module zap_front import zap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  zap_req_type in_data,
   output logic        out_valid,
   output zap_rot_type out_rot
);

   logic [AZ_W-1:0]  az_red;
   logic [AZ_W-1:0]  offset;
   zap_quad_type     quad_in;
   zap_quad_type     quad_ff;
   logic [REM_W-1:0] rem_in;
   logic [REM_W-1:0] rem_ff;
   logic [ZEN_W-1:0] zen_ff;
   logic             valid_a_ff;
   logic [REM_W+ANG_MUL_W-1:0] ang_prod;
   logic [REM_W+ANG_MUL_W-1:0] ang_round;
   zap_rot_type      rot_in;
   zap_rot_type      rot_ff;
   logic             valid_b_ff;

   always_comb begin
      az_red = (in_data.azimuth_deg >= FULL_Q8) ? in_data.azimuth_deg - FULL_Q8
                                                : in_data.azimuth_deg;
      priority if (az_red >= THREE_Q_Q8) begin
         quad_in = QUAD_FOURTH;
         offset  = THREE_Q_Q8;
      end else if (az_red >= HALF_Q8) begin
         quad_in = QUAD_THIRD;
         offset  = HALF_Q8;
      end else if (az_red >= QUARTER_Q8) begin
         quad_in = QUAD_SECOND;
         offset  = QUARTER_Q8;
      end else begin
         quad_in = QUAD_FIRST;
         offset  = '0;
      end
      rem_in = REM_W'(az_red - offset);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quad_ff <= quad_in;
         rem_ff  <= rem_in;
         zen_ff  <= in_data.zenith_deg;
      end
   end

   always_comb begin
      ang_prod   = (REM_W+ANG_MUL_W)'(rem_ff) * (REM_W+ANG_MUL_W)'(DEG_Q8_TO_RAD);
      ang_round  = ang_prod + (REM_W+ANG_MUL_W)'(128);
      rot_in.zen  = zen_ff;
      rot_in.quad = quad_ff;
      rot_in.x    = INV_GAIN_Q30;
      rot_in.y    = '0;
      rot_in.z    = $signed(ang_round[Z_W+7:8]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_rot   = rot_ff;

endmodule

@@ src/zap_rotate.sv @@
module zap_rotate import zap_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  zap_rot_type in_rot,
   output logic        out_valid,
   output zap_rot_type out_rot
);

   logic signed [XY_W-1:0] x_sh;
   logic signed [XY_W-1:0] y_sh;
   zap_rot_type            rot_in;
   zap_rot_type            rot_ff;
   logic                   valid_ff;

   always_comb begin
      x_sh = $signed(in_rot.x) >>> SHIFT;
      y_sh = $signed(in_rot.y) >>> SHIFT;
      rot_in.zen  = in_rot.zen;
      rot_in.quad = in_rot.quad;
      if ($signed(in_rot.z) >= 0) begin
         rot_in.x = in_rot.x - y_sh;
         rot_in.y = in_rot.y + x_sh;
         rot_in.z = in_rot.z - ATAN_Q30[SHIFT];
      end else begin
         rot_in.x = in_rot.x + y_sh;
         rot_in.y = in_rot.y - x_sh;
         rot_in.z = in_rot.z + ATAN_Q30[SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;

endmodule

@@ src/zap_scale.sv @@
module zap_scale import zap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  zap_rot_type in_rot,
   output logic        out_valid,
   output zap_rsp_type out_data
);

   localparam int STEPS = 7;

   logic [STEPS-1:0] valid_in;
   logic [STEPS-1:0] valid_ff;

   logic signed [XY_W-1:0] sn_in, cs_in, sn_ff, cs_ff;
   logic [ZEN_W-1:0]       zen1_ff, zen2_ff;
   logic signed [XY_W-1:0] abs_x, abs_y;
   logic [MAG_W-1:0]       mag_x_ff, mag_y_ff;
   logic                   neg_x2_ff, neg_y2_ff, neg_x3_ff, neg_y3_ff;
   logic                   neg_x4_ff, neg_y4_ff, neg_x5_ff, neg_y5_ff;
   logic                   neg_x6_ff, neg_y6_ff;
   logic [PROD_W-1:0]      p_x_ff, p_y_ff, sum_x, sum_y;
   logic [T_W-1:0]         t_x4_ff, t_y4_ff, t_x5_ff, t_y5_ff;
   logic [T_W+RECIP_W-1:0] rp_x, rp_y;
   logic [Q_W-1:0]         q0_x_ff, q0_y_ff;
   logic [T_W-1:0]         r_x, r_y;
   logic [Q_W-1:0]         q_x_in, q_y_in, q_x_ff, q_y_ff;
   zap_rsp_type            rsp_in, rsp_ff;

   function automatic logic signed [15:0] saturate(input logic neg, input logic [Q_W-1:0] q);
      logic [15:0] mag16;
      mag16 = q[15:0];
      if (neg) begin
         return (q >= NEG_LIMIT) ? 16'sh8000 : $signed(16'd0 - mag16);
      end
      return (q >= POS_LIMIT) ? 16'sh7fff : $signed(mag16);
   endfunction

   always_comb begin
      unique case (in_rot.quad)
         QUAD_FIRST: begin
            sn_in = in_rot.y;
            cs_in = in_rot.x;
         end
         QUAD_SECOND: begin
            sn_in = in_rot.x;
            cs_in = -in_rot.y;
         end
         QUAD_THIRD: begin
            sn_in = -in_rot.y;
            cs_in = -in_rot.x;
         end
         QUAD_FOURTH: begin
            sn_in = -in_rot.x;
            cs_in = in_rot.y;
         end
         default: begin
            sn_in = in_rot.y;
            cs_in = in_rot.x;
         end
      endcase
   end

   always_comb begin
      abs_x = (sn_ff < 0) ? -sn_ff : sn_ff;
      abs_y = (cs_ff < 0) ? -cs_ff : cs_ff;
      sum_x = p_x_ff + OUT_HALF;
      sum_y = p_y_ff + OUT_HALF;
      rp_x  = (T_W+RECIP_W)'(t_x4_ff) * (T_W+RECIP_W)'(RECIP_45);
      rp_y  = (T_W+RECIP_W)'(t_y4_ff) * (T_W+RECIP_W)'(RECIP_45);
      r_x   = t_x5_ff - T_W'(T_W'(q0_x_ff) * DIV_FACTOR);
      r_y   = t_y5_ff - T_W'(T_W'(q0_y_ff) * DIV_FACTOR);
      q_x_in = (r_x >= DIV_FACTOR) ? q0_x_ff + Q_W'(1) : q0_x_ff;
      q_y_in = (r_y >= DIV_FACTOR) ? q0_y_ff + Q_W'(1) : q0_y_ff;
      rsp_in.plane_x = saturate(neg_x6_ff, q_x_ff);
      rsp_in.plane_y = saturate(neg_y6_ff, q_y_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sn_ff     <= sn_in;
         cs_ff     <= cs_in;
         zen1_ff   <= in_rot.zen;
         neg_x2_ff <= sn_ff < 0;
         neg_y2_ff <= cs_ff < 0;
         mag_x_ff  <= abs_x[MAG_W-1:0];
         mag_y_ff  <= abs_y[MAG_W-1:0];
         zen2_ff   <= zen1_ff;
         p_x_ff    <= PROD_W'(zen2_ff) * PROD_W'(mag_x_ff);
         p_y_ff    <= PROD_W'(zen2_ff) * PROD_W'(mag_y_ff);
         neg_x3_ff <= neg_x2_ff;
         neg_y3_ff <= neg_y2_ff;
         t_x4_ff   <= sum_x[OUT_SHIFT+T_W-1:OUT_SHIFT];
         t_y4_ff   <= sum_y[OUT_SHIFT+T_W-1:OUT_SHIFT];
         neg_x4_ff <= neg_x3_ff;
         neg_y4_ff <= neg_y3_ff;
         q0_x_ff   <= rp_x[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
         q0_y_ff   <= rp_y[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
         t_x5_ff   <= t_x4_ff;
         t_y5_ff   <= t_y4_ff;
         neg_x5_ff <= neg_x4_ff;
         neg_y5_ff <= neg_y4_ff;
         q_x_ff    <= q_x_in;
         q_y_ff    <= q_y_in;
         neg_x6_ff <= neg_x5_ff;
         neg_y6_ff <= neg_y5_ff;
         rsp_ff    <= rsp_in;
      end
   end

   assign valid_in = {valid_ff[STEPS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_data  = rsp_ff;

endmodule

@@ src/zenith_azimuth_to_plane.sv @@
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   zap_req_type (zenith_deg, azimuth_deg)
// rsp_      out        rsp_valid/rsp_stall   zap_rsp_type (plane_x, plane_y)
//
// One item is accepted per cycle while req_stall is low; from acceptance to
// rsp_valid an item passes through the rotation stages (capped at 24), two
// angle stages, seven scaling stages and the output register.
// Reset is synchronous and clears only the valid bits of every stage.
// A stalled result holds in the output register, one further item parks in a
// skid register, and only then does req_stall rise and the pipeline hold.
module zenith_azimuth_to_plane import zap_pkg::*; #(
   parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  zap_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output zap_rsp_type rsp_data
);

`include "assert_macros.svh"

   localparam int STAGE_COUNT = (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;

   logic                 advance;
   zap_rot_type          rot [STAGE_COUNT+1];
   logic [STAGE_COUNT:0] rot_valid;
   logic                 fin_valid;
   zap_rsp_type          fin_data;
   logic                 take;
   logic                 push;
   logic                 rsp_valid_in, rsp_valid_ff;
   zap_rsp_type          rsp_data_in, rsp_data_ff;
   logic                 skid_valid_in, skid_valid_ff;
   zap_rsp_type          skid_data_in, skid_data_ff;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   zap_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (rot_valid[0]),
      .out_rot   (rot[0])
   );

   for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_rot
      zap_rotate #(.SHIFT(g)) u_rotate (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rot_valid[g]),
         .in_rot    (rot[g]),
         .out_valid (rot_valid[g+1]),
         .out_rot   (rot[g+1])
      );
   end

   zap_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rot_valid[STAGE_COUNT]),
      .in_rot    (rot[STAGE_COUNT]),
      .out_valid (fin_valid),
      .out_data  (fin_data)
   );

   always_comb begin
      take          = rsp_valid_ff && !rsp_stall;
      push          = advance && fin_valid;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_in  = fin_data;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = fin_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ZAP_ASSERT_SAME(a_skid_needs_output, clock, reset, skid_valid_ff, rsp_valid_ff, "skid item without an output item")
   `ZAP_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff, "skid item lost while output stalled")
   `ZAP_ASSERT_SAME(a_skid_fill_on_stall, clock, reset, $rose(skid_valid_ff), $past(rsp_valid_ff && rsp_stall), "skid filled without a stalled output")

endmodule
